// ----- src/crtp_pkg.sv -----
package crtp_pkg;

    // Table geometry: index is {u, v}, each a signed byte
    localparam int TABLE_ENTRIES = 65536;
    localparam int ADDR_W        = $clog2(TABLE_ENTRIES);
    localparam int BYTE_W        = 8;
    localparam int LABEL_W       = 3;
    localparam int MODE_W        = 2;

    // Configuration registers
    localparam int CFG_W     = 32;
    localparam int NUM_CFG   = 8;
    localparam int CFG_IDX_W = $clog2(NUM_CFG);
    localparam int NUM_LINES = NUM_CFG / 2;

    // Q16.16 line values: 32-bit slope times signed byte plus intercept fits in 41 bits
    localparam int Q_FRAC = 16;
    localparam int ACC_W  = CFG_W + BYTE_W + 1;

    // Register indexes (slope at even index, intercept at the odd one after it)
    localparam logic [CFG_IDX_W-1:0] REG_UH_SLOPE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UH_INTCP = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LH_SLOPE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LH_INTCP = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_US_SLOPE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_US_INTCP = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LS_SLOPE = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_LS_INTCP = 3'd7;

    // Command codes
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ADD   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

    // Byte markers used by the sweep
    localparam logic [BYTE_W-1:0] BYTE_LAST = 8'hff;
    localparam logic [BYTE_W-1:0] U_POS_MAX = 8'h7f;

    // Shift that takes a slope from u = 0 to u = -128
    localparam int U_NEG_SHIFT = BYTE_W - 1;

endpackage

// ----- src/chroma_region_table_painter.sv -----
// Chroma region table painter: a 65536 x 3-bit label table in one synchronous RAM,
// indexed by {u, v} (signed bytes). Clear and add commands sweep the whole table with
// one read-modify-write per cycle through the single RAM, each write-back registered
// behind its read. Line values slope*u+intercept are kept in four adders that step
// once per u row, so no multiplier is needed. After reset a clearing pass over all
// 65536 entries zeroes the RAM, with in_stall high; configuration writes are taken
// at all times but must only happen while the block is idle. A new item is taken
// while a finished result still waits on the output.
module chroma_region_table_painter (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [crtp_pkg::MODE_W-1:0]          mode,
    input  logic [crtp_pkg::LABEL_W-1:0]         label,
    input  logic [crtp_pkg::ADDR_W-1:0]          entry_index,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [crtp_pkg::MODE_W-1:0]          done_mode,
    output logic [crtp_pkg::LABEL_W-1:0]         entry_label,
    input  logic                                 cfg_we,
    input  logic [crtp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [crtp_pkg::CFG_W-1:0]           cfg_data
);

    localparam logic [2:0] ST_INIT   = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_SWEEP  = 3'd2;
    localparam logic [2:0] ST_RDWAIT = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    localparam logic [crtp_pkg::ADDR_W-1:0] POS_LAST =
        crtp_pkg::ADDR_W'(crtp_pkg::TABLE_ENTRIES - 1);

    logic [2:0]                        state_reg, state_next;
    logic [crtp_pkg::ADDR_W-1:0]       pos_reg, pos_next;
    logic [crtp_pkg::MODE_W-1:0]       mode_reg, mode_next;
    logic [crtp_pkg::LABEL_W-1:0]      label_reg, label_next;
    logic [crtp_pkg::LABEL_W-1:0]      res_label_reg, res_label_next;
    logic                              p_valid_reg, p_valid_next;
    logic [crtp_pkg::ADDR_W-1:0]       p_addr_reg;
    logic                              p_in_reg, p_in_next;
    logic                              out_valid_reg, out_valid_next;
    logic [crtp_pkg::MODE_W-1:0]       out_mode_reg, out_mode_next;
    logic [crtp_pkg::LABEL_W-1:0]      out_label_reg, out_label_next;

    logic signed [crtp_pkg::CFG_W-1:0] cfg_reg [crtp_pkg::NUM_CFG];
    logic signed [crtp_pkg::ACC_W-1:0] acc_reg [crtp_pkg::NUM_LINES];
    logic signed [crtp_pkg::ACC_W-1:0] acc_next [crtp_pkg::NUM_LINES];

    // Label RAM and its ports
    logic [crtp_pkg::LABEL_W-1:0]      label_mem [crtp_pkg::TABLE_ENTRIES];
    logic [crtp_pkg::LABEL_W-1:0]      rd_data_reg;
    logic                              mem_we;
    logic [crtp_pkg::ADDR_W-1:0]       mem_waddr;
    logic [crtp_pkg::LABEL_W-1:0]      mem_wdata;
    logic [crtp_pkg::ADDR_W-1:0]       mem_raddr;

    logic                              accept;
    logic                              out_free;
    logic [crtp_pkg::BYTE_W-1:0]       pos_u;
    logic [crtp_pkg::BYTE_W-1:0]       pos_v;
    logic signed [crtp_pkg::ACC_W-1:0] vq;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid   = out_valid_reg;
    assign done_mode   = out_mode_reg;
    assign entry_label = out_label_reg;

    assign pos_u = pos_reg[crtp_pkg::ADDR_W-1 -: crtp_pkg::BYTE_W];
    assign pos_v = pos_reg[crtp_pkg::BYTE_W-1:0];
    // v scaled to Q16.16
    assign vq = crtp_pkg::ACC_W'($signed(pos_v)) <<< crtp_pkg::Q_FRAC;

    // Region test for the entry issued this cycle
    always_comb
    begin
        p_in_next = (acc_reg[0] >= vq) && (acc_reg[1] <= vq) &&
                    (acc_reg[2] >= vq) && (acc_reg[3] <= vq);
    end

    // Line accumulators: start at u = 0, step one slope per u row, jump to u = -128
    always_comb
    begin
        for (int k = 0; k < crtp_pkg::NUM_LINES; k++)
        begin
            acc_next[k] = acc_reg[k];
            if (accept)
            begin
                acc_next[k] = crtp_pkg::ACC_W'(cfg_reg[crtp_pkg::CFG_IDX_W'(2 * k + 1)]);
            end
            else if (state_reg == ST_SWEEP && pos_v == crtp_pkg::BYTE_LAST)
            begin
                if (pos_u == crtp_pkg::U_POS_MAX)
                begin
                    acc_next[k] =
                        crtp_pkg::ACC_W'(cfg_reg[crtp_pkg::CFG_IDX_W'(2 * k + 1)]) -
                        (crtp_pkg::ACC_W'(cfg_reg[crtp_pkg::CFG_IDX_W'(2 * k)])
                            <<< crtp_pkg::U_NEG_SHIFT);
                end
                else
                begin
                    acc_next[k] = acc_reg[k] +
                        crtp_pkg::ACC_W'(cfg_reg[crtp_pkg::CFG_IDX_W'(2 * k)]);
                end
            end
        end
    end

    // RAM port control: clearing pass, or write-back of the entry read last cycle
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = p_addr_reg;
        mem_wdata = '0;
        mem_raddr = (state_reg == ST_SWEEP) ? pos_reg : entry_index;
        if (state_reg == ST_INIT)
        begin
            mem_we    = 1'b1;
            mem_waddr = pos_reg;
        end
        else if (p_valid_reg)
        begin
            if (mode_reg == crtp_pkg::MODE_CLEAR)
            begin
                mem_we = (label_reg == '0) || (rd_data_reg == label_reg);
            end
            else
            begin
                mem_we    = p_in_reg && ((rd_data_reg == '0) || (rd_data_reg >= label_reg));
                mem_wdata = label_reg;
            end
        end
    end

    // Command sequencer
    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        mode_next      = mode_reg;
        label_next     = label_reg;
        res_label_next = res_label_reg;
        p_valid_next   = 1'b0;
        out_valid_next = out_valid_reg && out_stall;
        out_mode_next  = out_mode_reg;
        out_label_next = out_label_reg;

        unique case (state_reg)
            ST_INIT:
            begin
                pos_next = pos_reg + 1'b1;
                if (pos_reg == POS_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    mode_next      = mode;
                    label_next     = label;
                    res_label_next = '0;
                    unique case (mode)
                        crtp_pkg::MODE_CLEAR: state_next = ST_SWEEP;
                        crtp_pkg::MODE_ADD:   state_next = ST_SWEEP;
                        crtp_pkg::MODE_READ:  state_next = ST_RDWAIT;
                        default:              state_next = ST_FINISH;
                    endcase
                end
            end
            ST_SWEEP:
            begin
                p_valid_next = 1'b1;
                pos_next     = pos_reg + 1'b1;
                if (pos_reg == POS_LAST)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_RDWAIT:
            begin
                res_label_next = rd_data_reg;
                state_next     = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_mode_next  = mode_reg;
                    out_label_next = res_label_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            pos_reg       <= '0;
            p_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            p_valid_reg   <= p_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < crtp_pkg::NUM_CFG; i++)
            begin
                cfg_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            cfg_reg[cfg_index] <= cfg_data;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        mode_reg      <= mode_next;
        label_reg     <= label_next;
        res_label_reg <= res_label_next;
        p_addr_reg    <= pos_reg;
        p_in_reg      <= p_in_next;
        out_mode_reg  <= out_mode_next;
        out_label_reg <= out_label_next;
        for (int k = 0; k < crtp_pkg::NUM_LINES; k++)
        begin
            acc_reg[k] <= acc_next[k];
        end
    end

    // Label RAM, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            label_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= label_mem[mem_raddr];
    end

    // Write-back stage only follows an issued sweep read
    assert property (@(posedge clk) disable iff (!rst_n)
        p_valid_reg |-> $past(state_reg) == ST_SWEEP)
        else $error("write-back without a sweep read");

    // A result only appears on leaving the finish state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_FINISH)
        else $error("result raised outside finish");

    // Only reads return a label
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_mode_reg != crtp_pkg::MODE_READ) |-> out_label_reg == '0)
        else $error("nonzero label on a non-read result");

    // Sweep position is back at zero whenever idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> pos_reg == '0)
        else $error("sweep position not reset at idle");

    // All table writes are done before a new item can enter
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !mem_we)
        else $error("table write while idle");

endmodule

// ----- verif/chroma_region_table_painter_test.sv -----
module chroma_region_table_painter_test;
    timeunit 1ns;
    timeprecision 1ps;

    // mode three has no package name; the block answers it without touching the table
    localparam logic [crtp_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

    localparam int STALL_LIMIT   = 4 * crtp_pkg::TABLE_ENTRIES;
    localparam int LONG_HOLD     = 300;
    localparam int SETTLE_CYCLES = 6;
    localparam int NUM_DIRECTED  = 23;
    localparam int NUM_RANDOM_PHASES = 3;
    localparam int ITEMS_PER_PHASE   = 25;

    typedef struct packed
    {
        logic [crtp_pkg::MODE_W-1:0]  mode;
        logic [crtp_pkg::LABEL_W-1:0] label;
    } done_rec_t;

    typedef struct
    {
        logic [crtp_pkg::MODE_W-1:0]  mode;
        logic [crtp_pkg::LABEL_W-1:0] label;
        logic [crtp_pkg::ADDR_W-1:0]  index;
        int                           phase;
        bit                           typed;
        logic [crtp_pkg::LABEL_W-1:0] typed_label;
    } directed_row_t;

    logic                           clk;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_stall;
    logic [crtp_pkg::MODE_W-1:0]    mode;
    logic [crtp_pkg::LABEL_W-1:0]   label;
    logic [crtp_pkg::ADDR_W-1:0]    entry_index;
    logic                           out_valid;
    logic                           out_stall;
    logic [crtp_pkg::MODE_W-1:0]    done_mode;
    logic [crtp_pkg::LABEL_W-1:0]   entry_label;
    logic                           cfg_we;
    logic [crtp_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [crtp_pkg::CFG_W-1:0]     cfg_data;

    // shadow copy of the block's table and line registers
    bit [crtp_pkg::LABEL_W-1:0]      label_shadow [crtp_pkg::TABLE_ENTRIES];
    bit signed [crtp_pkg::CFG_W-1:0] line_coef [crtp_pkg::NUM_CFG];
    done_rec_t                       pending_done [$];

    int failures      = 0;
    int idle_cycles   = 0;
    int rush_left     = 0;
    bit long_hold_req = 1'b0;
    int send_run_left = 0;
    bit send_run_idle = 1'b0;
    int recv_run_left = 0;
    bit recv_run_idle = 1'b0;

    // line registers per directed phase, in register index order
    logic [crtp_pkg::CFG_W-1:0] phase_cfg [0:3][0:crtp_pkg::NUM_CFG-1] = '{
        '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0},
        // wide hue, saturation band |v - u| <= 20
        '{32'h0, 32'h7fff_ffff, 32'h0, 32'h8000_0000,
          32'h0001_0000, 32'h0014_0000, 32'h0001_0000, 32'hffec_0000},
        // extreme slopes and intercepts
        '{32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
          32'h7fff_ffff, 32'h0, 32'h8000_0000, 32'h0},
        // crossed hue lines: nothing lies between them
        '{32'h0, 32'hfff6_0000, 32'h0, 32'h000a_0000,
          32'h0, 32'h7fff_ffff, 32'h0, 32'h8000_0000}
    };

    directed_row_t directed_rows [NUM_DIRECTED] = '{
        '{crtp_pkg::MODE_READ,  3'd0, 16'h0000, 0, 1'b1, 3'd0},
        '{crtp_pkg::MODE_READ,  3'd0, 16'hffff, 0, 1'b1, 3'd0},
        '{MODE_UNUSED,          3'd7, 16'hffff, 0, 1'b1, 3'd0},
        '{crtp_pkg::MODE_ADD,   3'd7, 16'h1234, 0, 1'b0, 3'd0},
        '{crtp_pkg::MODE_READ,  3'd0, 16'h8000, 0, 1'b0, 3'd0},
        '{crtp_pkg::MODE_READ,  3'd0, 16'h7f01, 0, 1'b0, 3'd0},
        '{crtp_pkg::MODE_ADD,   3'd5, 16'h0000, 1, 1'b0, 3'd0},
        '{crtp_pkg::MODE_READ,  3'd0, 16'h0000, 1, 1'b0, 3'd0},
        '{crtp_pkg::MODE_READ,  3'd0, 16'h8000, 1, 1'b0, 3'd0},
        '{crtp_pkg::MODE_READ,  3'd0, 16'h1428, 1, 1'b0, 3'd0},
        '{crtp_pkg::MODE_READ,  3'd0, 16'h1429, 1, 1'b0, 3'd0},
        '{crtp_pkg::MODE_CLEAR, 3'd7, 16'h0000, 1, 1'b1, 3'd0},
        '{crtp_pkg::MODE_READ,  3'd0, 16'h8000, 1, 1'b0, 3'd0},
        '{crtp_pkg::MODE_ADD,   3'd3, 16'hffff, 2, 1'b0, 3'd0},
        '{crtp_pkg::MODE_READ,  3'd0, 16'h0105, 2, 1'b0, 3'd0},
        '{crtp_pkg::MODE_READ,  3'd0, 16'hff00, 2, 1'b0, 3'd0},
        '{crtp_pkg::MODE_ADD,   3'd0, 16'h0000, 2, 1'b0, 3'd0},
        '{crtp_pkg::MODE_READ,  3'd0, 16'h7f80, 2, 1'b0, 3'd0},
        '{crtp_pkg::MODE_ADD,   3'd1, 16'h0000, 3, 1'b0, 3'd0},
        '{crtp_pkg::MODE_READ,  3'd0, 16'h1010, 3, 1'b0, 3'd0},
        '{crtp_pkg::MODE_CLEAR, 3'd0, 16'h0000, 3, 1'b1, 3'd0},
        '{crtp_pkg::MODE_READ,  3'd0, 16'h0000, 3, 1'b1, 3'd0},
        '{crtp_pkg::MODE_READ,  3'd0, 16'h4b2d, 3, 1'b1, 3'd0}
    };

    chroma_region_table_painter uut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .mode        (mode),
        .label       (label),
        .entry_index (entry_index),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .done_mode   (done_mode),
        .entry_label (entry_label),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // value of one line at row u, full width, Q16.16
    function automatic longint line_at(input logic [crtp_pkg::CFG_IDX_W-1:0] slope_reg,
                                       input logic [crtp_pkg::CFG_IDX_W-1:0] intcp_reg,
                                       input longint u);
        return longint'(line_coef[slope_reg]) * u + longint'(line_coef[intcp_reg]);
    endfunction

    // on or between both hue lines and both saturation lines
    function automatic bit in_chroma_region(input logic [crtp_pkg::ADDR_W-1:0] at);
        longint u;
        longint vq;
        u  = longint'($signed(at[crtp_pkg::ADDR_W-1:crtp_pkg::BYTE_W]));
        vq = longint'($signed(at[crtp_pkg::BYTE_W-1:0])) * (64'sd1 <<< crtp_pkg::Q_FRAC);
        return line_at(crtp_pkg::REG_UH_SLOPE, crtp_pkg::REG_UH_INTCP, u) >= vq
            && line_at(crtp_pkg::REG_LH_SLOPE, crtp_pkg::REG_LH_INTCP, u) <= vq
            && line_at(crtp_pkg::REG_US_SLOPE, crtp_pkg::REG_US_INTCP, u) >= vq
            && line_at(crtp_pkg::REG_LS_SLOPE, crtp_pkg::REG_LS_INTCP, u) <= vq;
    endfunction

    // apply one command to the shadow table; returns the label a read sees
    task automatic run_table_command(input logic [crtp_pkg::MODE_W-1:0] m,
                                     input logic [crtp_pkg::LABEL_W-1:0] lb,
                                     input logic [crtp_pkg::ADDR_W-1:0] ix,
                                     output logic [crtp_pkg::LABEL_W-1:0] seen);
        logic [crtp_pkg::ADDR_W-1:0] at;
        seen = '0;
        case (m)
            crtp_pkg::MODE_CLEAR:
            begin
                for (int k = 0; k < crtp_pkg::TABLE_ENTRIES; k++)
                begin
                    at = crtp_pkg::ADDR_W'(k);
                    if (lb == 0 || label_shadow[at] == lb)
                        label_shadow[at] = '0;
                end
            end
            crtp_pkg::MODE_ADD:
            begin
                // paint rule: only empty entries or ones holding an equal or higher label
                for (int k = 0; k < crtp_pkg::TABLE_ENTRIES; k++)
                begin
                    at = crtp_pkg::ADDR_W'(k);
                    if ((label_shadow[at] == 0 || label_shadow[at] >= lb) &&
                        in_chroma_region(at))
                        label_shadow[at] = lb;
                end
            end
            crtp_pkg::MODE_READ:
                seen = label_shadow[ix];
            default:
                seen = '0;
        endcase
    endtask

    // first painted entry at or after a point, so reads land on labels
    function automatic logic [crtp_pkg::ADDR_W-1:0] next_painted(
        input logic [crtp_pkg::ADDR_W-1:0] from);
        logic [crtp_pkg::ADDR_W-1:0] at;
        for (int k = 0; k < crtp_pkg::TABLE_ENTRIES; k++)
        begin
            at = from + crtp_pkg::ADDR_W'(k);
            if (label_shadow[at] != 0)
                return at;
        end
        return from;
    endfunction

    // idle pattern: runs of random waits and runs of none, each run's kind drawn at random
    task automatic draw_wait(inout int run_left, inout bit run_idle, output int cycles);
        if (run_left == 0)
        begin
            run_left = $urandom_range(4, 24);
            run_idle = $urandom_range(0, 2) != 0;
        end
        run_left--;
        cycles = run_idle ? $urandom_range(0, 6) : 0;
    endtask

    task automatic cfg_write(input logic [crtp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [crtp_pkg::CFG_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        line_coef[idx] = val;
    endtask

    // random line: mostly moderate, sometimes extreme or fully random
    task automatic pick_line(input logic [crtp_pkg::CFG_IDX_W-1:0] slope_reg,
                             input logic [crtp_pkg::CFG_IDX_W-1:0] intcp_reg, input bit upper);
        logic [crtp_pkg::CFG_W-1:0] slope;
        logic [crtp_pkg::CFG_W-1:0] intcp;
        logic [crtp_pkg::CFG_W-1:0] mag;
        int                         style;
        style = $urandom_range(0, 7);
        if (style == 0)
        begin
            slope = $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
            intcp = $urandom;
        end
        else if (style == 1)
        begin
            slope = $urandom;
            intcp = $urandom;
        end
        else
        begin
            slope = crtp_pkg::CFG_W'($urandom_range(0, 32'h6_0000)) - 32'h3_0000;
            mag   = crtp_pkg::CFG_W'($urandom_range(0, 32'h64_0000));
            intcp = upper ? mag : -mag;
        end
        cfg_write(slope_reg, slope);
        cfg_write(intcp_reg, intcp);
    endtask

    // stop sending and wait for every outstanding result
    task automatic settle_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_done.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic issue_command(input logic [crtp_pkg::MODE_W-1:0] m,
                                 input logic [crtp_pkg::LABEL_W-1:0] lb,
                                 input logic [crtp_pkg::ADDR_W-1:0] ix, input bit typed,
                                 input logic [crtp_pkg::LABEL_W-1:0] typed_label);
        int                           gap;
        logic [crtp_pkg::LABEL_W-1:0] seen;
        done_rec_t                    rec;
        if (rush_left > 0)
        begin
            gap = 0;
            rush_left--;
        end
        else
            draw_wait(send_run_left, send_run_idle, gap);
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid    <= 1'b1;
        mode        <= m;
        label       <= lb;
        entry_index <= ix;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        run_table_command(m, lb, ix, seen);
        rec.mode  = m;
        rec.label = typed ? typed_label : seen;
        pending_done.push_back(rec);
    endtask

    // stimulus
    initial
    begin
        int                          cur_phase;
        int                          sel;
        int                          sweeps_left;
        logic [crtp_pkg::MODE_W-1:0] m;
        logic [crtp_pkg::ADDR_W-1:0] ix;

        rst_n       = 1'b0;
        in_valid    = 1'b0;
        mode        = '0;
        label       = '0;
        entry_index = '0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // the block clears its table after reset
        repeat (2) @(posedge clk);
        while (in_stall)
            @(posedge clk);

        // directed table; line registers change between phases
        cur_phase = 0;
        for (int r = 0; r < NUM_DIRECTED; r++)
        begin
            if (directed_rows[r].phase != cur_phase)
            begin
                settle_idle();
                cur_phase = directed_rows[r].phase;
                for (int k = 0; k < crtp_pkg::NUM_CFG; k++)
                    cfg_write(crtp_pkg::CFG_IDX_W'(k), phase_cfg[cur_phase][k]);
                @(negedge clk);
                cfg_we <= 1'b0;
            end
            issue_command(directed_rows[r].mode, directed_rows[r].label,
                          directed_rows[r].index, directed_rows[r].typed,
                          directed_rows[r].typed_label);
        end

        // random phases: new region, one add, mostly reads; at most two sweeps over all
        sweeps_left = 2;
        for (int p = 0; p < NUM_RANDOM_PHASES; p++)
        begin
            settle_idle();
            pick_line(crtp_pkg::REG_UH_SLOPE, crtp_pkg::REG_UH_INTCP, 1'b1);
            pick_line(crtp_pkg::REG_LH_SLOPE, crtp_pkg::REG_LH_INTCP, 1'b0);
            pick_line(crtp_pkg::REG_US_SLOPE, crtp_pkg::REG_US_INTCP, 1'b1);
            pick_line(crtp_pkg::REG_LS_SLOPE, crtp_pkg::REG_LS_INTCP, 1'b0);
            @(negedge clk);
            cfg_we <= 1'b0;
            issue_command(crtp_pkg::MODE_ADD, crtp_pkg::LABEL_W'($urandom_range(0, 7)),
                          crtp_pkg::ADDR_W'($urandom), 1'b0, '0);
            if (p == 0)
            begin
                // back-to-back commands, mostly reads, against a long output hold-off
                long_hold_req = 1'b1;
                rush_left     = 12;
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                sel = $urandom_range(0, 19);
                if (sel == 0 && sweeps_left > 0)
                begin
                    sweeps_left--;
                    m = $urandom_range(0, 1) ? crtp_pkg::MODE_ADD : crtp_pkg::MODE_CLEAR;
                end
                else if (sel == 1)
                    m = MODE_UNUSED;
                else
                    m = crtp_pkg::MODE_READ;
                ix = crtp_pkg::ADDR_W'($urandom);
                if (m == crtp_pkg::MODE_READ && $urandom_range(0, 1))
                    ix = next_painted(ix);
                issue_command(m, crtp_pkg::LABEL_W'($urandom_range(0, 7)), ix, 1'b0, '0);
            end
        end

        settle_idle();
        if (failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // result side: random stalls, one long hold-off on request
    initial
    begin
        int        hold;
        done_rec_t want;
        out_stall = 1'b0;
        forever
        begin
            draw_wait(recv_run_left, recv_run_idle, hold);
            if (long_hold_req)
            begin
                hold          = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            if (hold > 0)
            begin
                @(negedge clk);
                out_stall <= 1'b1;
                repeat (hold - 1) @(negedge clk);
            end
            @(negedge clk);
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            if (pending_done.size() == 0)
            begin
                $error("done_mode %0d arrived with no command outstanding", done_mode);
                failures++;
            end
            else
            begin
                want = pending_done.pop_front();
                if (done_mode !== want.mode)
                begin
                    $error("done_mode: expected %0d, got %0d", want.mode, done_mode);
                    failures++;
                end
                if (entry_label !== want.label)
                begin
                    $error("entry_label: expected %0d, got %0d", want.label, entry_label);
                    failures++;
                end
            end
        end
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles == STALL_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule

// ----- chroma_region_table_painter.f -----
src/crtp_pkg.sv
src/chroma_region_table_painter.sv
verif/chroma_region_table_painter_test.sv
